### hw/rtl/signed_integer_divider_unit_macros.svh
// assertion helpers for the signed integer divider unit
// the macros expect clk_i and rst_ni in scope
`ifndef SIGNED_INTEGER_DIVIDER_UNIT_MACROS_SVH
`define SIGNED_INTEGER_DIVIDER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SIDU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SIDU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sidu_pkg.sv
`timescale 1ns / 1ps

package sidu_pkg;

  // operand width used when the top level is not overridden
  localparam int unsigned SIDU_DEFAULT_WIDTH = 32;

  // sign and exception bits that ride along with each request
  typedef struct packed {
    logic neg_quo;   // quotient must be negated at the end
    logic neg_rem;   // remainder must be negated at the end
    logic div_zero;  // divisor was zero
  } sidu_flags_t;

endpackage

### hw/rtl/sidu_step.sv
`timescale 1ns / 1ps

// one restoring division step with its own pipeline register
module sidu_step import sidu_pkg::*; #(
  parameter int unsigned WIDTH = SIDU_DEFAULT_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [WIDTH-1:0] rem_i,
  input  logic [WIDTH-1:0] quo_i,
  input  logic [WIDTH-1:0] div_i,
  input  sidu_flags_t      flags_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH-1:0] quo_o,
  output logic [WIDTH-1:0] div_o,
  output sidu_flags_t      flags_o
);

  logic             valid_q;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] div_q;
  sidu_flags_t      flags_q;
  logic [WIDTH:0]   diff;
  logic             qbit;

  // trial subtract of the divisor from the shifted partial remainder
  assign diff  = {rem_i, quo_i[WIDTH-1]} - {1'b0, div_i};
  assign qbit  = ~diff[WIDTH];
  assign rem_d = qbit ? diff[WIDTH-1:0] : {rem_i[WIDTH-2:0], quo_i[WIDTH-1]};
  assign quo_d = {quo_i[WIDTH-2:0], qbit};

  assign stall_o = valid_q & stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      div_q   <= div_i;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign div_o   = div_q;
  assign flags_o = flags_q;

endmodule

### hw/rtl/signed_integer_divider_unit.sv
// signed integer divider, quotient truncated toward zero, remainder takes the dividend's sign
// pipeline: magnitude stage, one stage per quotient bit,
//   sign fix-up stage that doubles as the output register
// throughput: one request per cycle unless in_stall_o is raised; every stage holds its own request, so bubbles collapse
// reset: rst_ni clears all valid bits at once, payload registers are not reset
`timescale 1ns / 1ps

`include "signed_integer_divider_unit_macros.svh"

module signed_integer_divider_unit import sidu_pkg::*; #(
  parameter int unsigned WIDTH = SIDU_DEFAULT_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request side
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [WIDTH-1:0] dividend_i,
  input  logic signed [WIDTH-1:0] divisor_i,
  // result side
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [WIDTH-1:0] quotient_o,
  output logic signed [WIDTH-1:0] remainder_o,
  output logic                    divide_by_zero_o
);

  // ---------------------------------------------------------------------------
  // front stage: split operands into sign and unsigned magnitude
  // the magnitude of the most negative value is representable as unsigned,
  // so no special path is needed for it
  // ---------------------------------------------------------------------------
  logic             front_valid_q;
  logic [WIDTH-1:0] front_quo_q;   // dividend magnitude, shifted out msb first
  logic [WIDTH-1:0] front_div_q;   // divisor magnitude
  sidu_flags_t      front_flags_q;
  logic             front_stall;

  logic             sign_a, sign_b;
  logic [WIDTH-1:0] mag_a, mag_b;
  sidu_flags_t      front_flags_d;

  assign sign_a = dividend_i[WIDTH-1];
  assign sign_b = divisor_i[WIDTH-1];
  assign mag_a  = sign_a ? ({WIDTH{1'b0}} - dividend_i) : dividend_i;
  assign mag_b  = sign_b ? ({WIDTH{1'b0}} - divisor_i)  : divisor_i;

  always_comb begin
    front_flags_d          = '0;
    front_flags_d.neg_quo  = sign_a ^ sign_b;
    front_flags_d.neg_rem  = sign_a;
    front_flags_d.div_zero = (divisor_i == '0);
  end

  // stall chain between stages, index k is the stall seen by the feeder of step k
  logic             valid_w [0:WIDTH];
  logic             stall_w [0:WIDTH];
  logic [WIDTH-1:0] rem_w   [0:WIDTH];
  logic [WIDTH-1:0] quo_w   [0:WIDTH];
  logic [WIDTH-1:0] div_w   [0:WIDTH];
  sidu_flags_t      flags_w [0:WIDTH];

  assign front_stall = front_valid_q & stall_w[0];
  assign in_stall_o  = front_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else if (!front_stall) begin
      front_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!front_stall && in_valid_i) begin
      front_quo_q   <= mag_a;
      front_div_q   <= mag_b;
      front_flags_q <= front_flags_d;
    end
  end

  // ---------------------------------------------------------------------------
  // restoring division, one quotient bit per stage
  // a zero divisor simply runs through and is masked at the end
  // ---------------------------------------------------------------------------
  assign valid_w[0] = front_valid_q;
  assign rem_w[0]   = '0;
  assign quo_w[0]   = front_quo_q;
  assign div_w[0]   = front_div_q;
  assign flags_w[0] = front_flags_q;

  for (genvar k = 0; k < WIDTH; k++) begin : g_step
    sidu_step #(
      .WIDTH(WIDTH)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[k]),
      .stall_o (stall_w[k]),
      .rem_i   (rem_w[k]),
      .quo_i   (quo_w[k]),
      .div_i   (div_w[k]),
      .flags_i (flags_w[k]),
      .valid_o (valid_w[k+1]),
      .stall_i (stall_w[k+1]),
      .rem_o   (rem_w[k+1]),
      .quo_o   (quo_w[k+1]),
      .div_o   (div_w[k+1]),
      .flags_o (flags_w[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // back stage: restore signs, force zero results on a zero divisor
  // most negative / -1 falls out naturally: magnitude quotient wraps to itself
  // ---------------------------------------------------------------------------
  logic             out_valid_q;
  logic [WIDTH-1:0] out_quo_q, out_quo_d;
  logic [WIDTH-1:0] out_rem_q, out_rem_d;
  logic             out_dz_q;
  logic             back_stall;

  always_comb begin
    out_quo_d = flags_w[WIDTH].neg_quo ? ({WIDTH{1'b0}} - quo_w[WIDTH]) : quo_w[WIDTH];
    out_rem_d = flags_w[WIDTH].neg_rem ? ({WIDTH{1'b0}} - rem_w[WIDTH]) : rem_w[WIDTH];
    if (flags_w[WIDTH].div_zero) begin
      out_quo_d = '0;
      out_rem_d = '0;
    end
  end

  assign back_stall     = out_valid_q & out_stall_i;
  assign stall_w[WIDTH] = back_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!back_stall) begin
      out_valid_q <= valid_w[WIDTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!back_stall && valid_w[WIDTH]) begin
      out_quo_q <= out_quo_d;
      out_rem_q <= out_rem_d;
      out_dz_q  <= flags_w[WIDTH].div_zero;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign quotient_o       = $signed(out_quo_q);
  assign remainder_o      = $signed(out_rem_q);
  assign divide_by_zero_o = out_dz_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `SIDU_ASSERT_IMP(a_dz_zero_results, out_valid_o && divide_by_zero_o, quotient_o == '0 && remainder_o == '0, "zero divisor gave nonzero result")
  `SIDU_ASSERT_IMP(a_rem_below_divisor, valid_w[WIDTH] && !flags_w[WIDTH].div_zero, rem_w[WIDTH] < div_w[WIDTH], "final partial remainder not below divisor")
  `SIDU_ASSERT_NEXT(a_accept_fills_front, in_valid_i && !in_stall_o, front_valid_q, "accepted request missing from front stage")
  `SIDU_ASSERT_IMP(a_stall_only_when_full, in_stall_o, front_valid_q, "request side stalled with empty front stage")

endmodule

### tb/signed_integer_divider_unit_tb.sv
`timescale 1ns / 1ps

module signed_integer_divider_unit_tb;
  import sidu_pkg::*;

  localparam int W = SIDU_DEFAULT_WIDTH;
  // magnitude stage, one stage per quotient bit, sign fix-up
  localparam int LATENCY = W + 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQUESTS = 700;
  // long enough to fill every stage of the pipeline and back up the input
  localparam int HOLD_OFF_CYCLES = 4 * LATENCY;
  localparam int HOLD_OFF_AFTER = 150;

  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = ~MOST_NEG;
  localparam logic [W-1:0] MINUS_ONE = '1;
  localparam logic [W-1:0] ZERO = '0;
  localparam logic [W-1:0] ONE = W'(1);

  typedef struct packed {
    logic [W-1:0] quotient;
    logic [W-1:0] remainder;
    logic         divide_by_zero;
  } div_result_t;

  // known rows carry their answer, the rest go through the predictor
  typedef struct packed {
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic         known;
    logic [W-1:0] quotient;
    logic [W-1:0] remainder;
    logic         divide_by_zero;
  } directed_row_t;

  typedef enum int {
    STALL_NONE,
    STALL_SPARSE,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  localparam int NUM_DIRECTED = 24;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{ZERO,      ZERO,      1'b1, ZERO,         ZERO,      1'b1},
    '{MOST_POS,  ZERO,      1'b1, ZERO,         ZERO,      1'b1},
    '{MOST_NEG,  ZERO,      1'b1, ZERO,         ZERO,      1'b1},
    '{MINUS_ONE, ZERO,      1'b1, ZERO,         ZERO,      1'b1},
    '{MOST_NEG,  MINUS_ONE, 1'b1, MOST_NEG,     ZERO,      1'b0},
    '{MOST_POS,  ONE,       1'b1, MOST_POS,     ZERO,      1'b0},
    '{MOST_NEG,  ONE,       1'b1, MOST_NEG,     ZERO,      1'b0},
    '{MOST_POS,  MINUS_ONE, 1'b1, MOST_NEG + 1, ZERO,      1'b0},
    '{MOST_NEG,  MOST_NEG,  1'b1, ONE,          ZERO,      1'b0},
    '{MOST_POS,  MOST_POS,  1'b1, ONE,          ZERO,      1'b0},
    '{MOST_POS,  MOST_NEG,  1'b1, ZERO,         MOST_POS,  1'b0},
    '{MOST_NEG,  MOST_POS,  1'b1, MINUS_ONE,    MINUS_ONE, 1'b0},
    '{ZERO,      MOST_NEG,  1'b1, ZERO,         ZERO,      1'b0},
    '{W'(7),     W'(2),     1'b0, ZERO,         ZERO,      1'b0},
    '{W'(-7),    W'(2),     1'b0, ZERO,         ZERO,      1'b0},
    '{W'(7),     W'(-2),    1'b0, ZERO,         ZERO,      1'b0},
    '{W'(-7),    W'(-2),    1'b0, ZERO,         ZERO,      1'b0},
    '{ONE,       MOST_POS,  1'b0, ZERO,         ZERO,      1'b0},
    '{MINUS_ONE, MINUS_ONE, 1'b0, ZERO,         ZERO,      1'b0},
    '{MOST_NEG,  W'(2),     1'b0, ZERO,         ZERO,      1'b0},
    '{{(W/2){2'b10}}, {(W/2){2'b01}}, 1'b0, ZERO, ZERO,    1'b0},
    '{{(W/2){2'b01}}, {(W/2){2'b10}}, 1'b0, ZERO, ZERO,    1'b0},
    '{W'(12345), W'(-7),    1'b0, ZERO,         ZERO,      1'b0},
    '{W'(-100),  W'(10),    1'b0, ZERO,         ZERO,      1'b0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic signed [W-1:0] dividend_i;
  logic signed [W-1:0] divisor_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic signed [W-1:0] quotient_o;
  logic signed [W-1:0] remainder_o;
  logic                divide_by_zero_o;

  div_result_t pending_results[$];
  int          mismatch_count = 0;
  int          result_count = 0;
  int          accepted_count = 0;
  int          burst_left = 0;
  int          cycle_count = 0;

  signed_integer_divider_unit #(
    .WIDTH(W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .dividend_i      (dividend_i),
    .divisor_i       (divisor_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .quotient_o      (quotient_o),
    .remainder_o     (remainder_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // truncating signed division on unsigned magnitudes
  function automatic div_result_t divide_toward_zero(input logic [W-1:0] num,
                                                     input logic [W-1:0] den);
    div_result_t  res;
    logic         neg_num;
    logic         neg_den;
    logic [W-1:0] mag_num;
    logic [W-1:0] mag_den;
    logic [W-1:0] quo;
    logic [W-1:0] rem;
    if (den == ZERO) begin
      res.quotient = ZERO;
      res.remainder = ZERO;
      res.divide_by_zero = 1'b1;
      return res;
    end
    neg_num = num[W-1];
    neg_den = den[W-1];
    mag_num = neg_num ? ~num + ONE : num;
    mag_den = neg_den ? ~den + ONE : den;
    quo = mag_num / mag_den;
    rem = mag_num % mag_den;
    if (neg_num ^ neg_den) quo = ~quo + ONE;
    if (neg_num) rem = ~rem + ONE;
    res.quotient = quo;
    res.remainder = rem;
    res.divide_by_zero = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [W-1:0] expected,
                                 input logic [W-1:0] got);
    $display("mismatch in %s at result %0d: expected %h, got %h", field, result_count,
             expected, got);
    mismatch_count++;
  endtask

  // offers one request, in bursts with random gaps, and waits for acceptance
  task automatic offer_request(input logic [W-1:0] num, input logic [W-1:0] den,
                               input div_result_t expected);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        dividend_i <= W'({$urandom, $urandom});
        divisor_i <= W'({$urandom, $urandom});
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    dividend_i <= num;
    divisor_i <= den;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(expected);
    accepted_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    div_result_t expected;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", ZERO, quotient_o);
      end else begin
        expected = pending_results.pop_front();
        if (quotient_o !== expected.quotient)
          report_mismatch("quotient", expected.quotient, quotient_o);
        if (remainder_o !== expected.remainder)
          report_mismatch("remainder", expected.remainder, remainder_o);
        if (divide_by_zero_o !== expected.divide_by_zero)
          report_mismatch("divide_by_zero", W'(expected.divide_by_zero),
                          W'(divide_by_zero_o));
      end
      result_count++;
    end
  end

  // receiver: phases of its own, plus one long hold-off to back up the pipeline
  initial begin
    stall_mode_e mode;
    int          span;
    int          step;
    bit          held_off;
    held_off = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && accepted_count >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 150);
      for (step = 0; step < span; step++) begin
        case (mode)
          STALL_NONE:     out_stall_i <= 1'b0;
          STALL_SPARSE:   out_stall_i <= ($urandom_range(0, 99) < 25);
          STALL_PERIODIC: out_stall_i <= (step % 3 == 0);
          default:        out_stall_i <= ($urandom_range(0, 99) < 75);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // request stream
  initial begin
    div_result_t  expected;
    logic [W-1:0] num;
    logic [W-1:0] den;
    int           row;
    int           count;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    dividend_i = '0;
    divisor_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < NUM_DIRECTED; row++) begin
      if (directed_rows[row].known) begin
        expected.quotient = directed_rows[row].quotient;
        expected.remainder = directed_rows[row].remainder;
        expected.divide_by_zero = directed_rows[row].divide_by_zero;
      end else begin
        expected = divide_toward_zero(directed_rows[row].dividend, directed_rows[row].divisor);
      end
      offer_request(directed_rows[row].dividend, directed_rows[row].divisor, expected);
    end

    for (count = 0; count < RANDOM_REQUESTS; count++) begin
      num = W'({$urandom, $urandom});
      den = W'({$urandom, $urandom});
      case ($urandom_range(0, 9))
        5: den = W'($signed($urandom_range(0, 32)) - 16);
        6: den = ZERO;
        7: den = $urandom_range(0, 1) ? ONE : MINUS_ONE;
        8: num = $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
        9: num = W'($signed($urandom_range(0, 200)) - 100);
        default: ;
      endcase
      offer_request(num, den, divide_toward_zero(num, den));
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
